// ===== design/modbus_rtu_response_checker_assert.svh =====
// Assertion macros used by the checker file of the Modbus RTU response checker.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mrc_pkg.sv =====
// Package with item types, status codes, constants and the CRC-16 byte update.
`default_nettype none

package mrc_pkg;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_CRC_ERR   = 3'd2;
	localparam logic [2:0] ST_EXCEPTION = 3'd3;
	localparam logic [2:0] ST_NO_DATA   = 3'd4;

	// Function codes that read single bits
	localparam logic [7:0] FC_READ_COILS    = 8'h01;
	localparam logic [7:0] FC_READ_DISCRETE = 8'h02;

	// CRC-16 constants
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Exception flag in the function byte
	localparam int EXC_FLAG_BIT = 7;

	// Register map: index taken from the word address
	localparam logic REG_BUFFER_LIMIT = 1'b0;
	localparam logic [8:0] BUFFER_LIMIT_RESET = 9'd16;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
		logic [7:0] request_function;
	} mrc_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  frame_length;
		logic [7:0]  exception_code;
		logic [15:0] raw_value;
	} mrc_out_t;

	// One byte of the reflected CRC-16, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/mrc_apb_regs.sv =====
// APB register block holding the buffer limit.
`default_nettype none

module mrc_apb_regs import mrc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [8:0]  buffer_limit
);

	logic wr_en;
	logic [8:0] buffer_limit_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Write the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_limit_q <= BUFFER_LIMIT_RESET;
		end else if (wr_en && (paddr[2] == REG_BUFFER_LIMIT)) begin
			buffer_limit_q <= pwdata[8:0];
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == REG_BUFFER_LIMIT) begin
			prdata = {23'd0, buffer_limit_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign buffer_limit = buffer_limit_q;

endmodule

`default_nettype wire

// ===== design/modbus_rtu_response_checker.sv =====
// A closing byte's result passes the input register, then the result register, whose out_valid
// marks it valid.
// Throughput: one byte per cycle while no closing byte is stalled; the CRC-16 byte update is one combinational step.
// A closing byte waits in the input register only while a previous result is stalled.
// Reset: buffer limit returns to 16, CRC to 0xFFFF, the frame state and both stages clear.
// Top level of the Modbus RTU response checker.
`default_nettype none

module modbus_rtu_response_checker import mrc_pkg::*; #(
	parameter int MAX_FRAME = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire mrc_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output mrc_out_t         out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// Count width: enough for MAX_FRAME, never more than the 9-bit limit register needs
	localparam int CNT_W = ($clog2(MAX_FRAME + 1) < 9) ? $clog2(MAX_FRAME + 1) : 9;

	logic [8:0] buffer_limit;

	logic        in_valid_s1;
	mrc_in_t     in_data_s1;
	logic        out_valid_q;
	mrc_out_t    out_data_q;

	logic [15:0]      crc_q;
	logic [7:0]       dly0_q;
	logic [7:0]       dly1_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       hdr_q [4];

	logic [CNT_W-1:0] eff_limit;
	logic             keep;
	logic [15:0]      crc_n;
	logic [7:0]       dly0_n;
	logic [7:0]       dly1_n;
	logic [CNT_W-1:0] count_n;
	logic [7:0]       hdr_n [4];
	logic             out_free;
	logic             advance;
	logic             bit_read;
	mrc_out_t         result;

	mrc_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.buffer_limit (buffer_limit)
	);

	// Handshake: only a closing byte needs the result register free
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = in_valid_s1 && (!in_data_s1.end_of_frame || out_free);
	assign in_stall = in_valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	// Effective limit is the smaller of the register and MAX_FRAME
	always_comb begin
		if (32'(buffer_limit) < MAX_FRAME) begin
			eff_limit = CNT_W'(buffer_limit);
		end else begin
			eff_limit = CNT_W'(MAX_FRAME);
		end
	end

	// Next frame state for the byte in the input register
	assign keep    = count_q < eff_limit;
	assign crc_n   = (keep && (count_q >= CNT_W'(2))) ? crc_byte(crc_q, dly0_q) : crc_q;
	assign dly0_n  = keep ? dly1_q : dly0_q;
	assign dly1_n  = keep ? in_data_s1.rx_byte : dly1_q;
	assign count_n = keep ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hdr_n[i] = (keep && (count_q == CNT_W'(i + 1))) ? in_data_s1.rx_byte : hdr_q[i];
		end
	end

	// Evaluate the closed frame
	assign bit_read = (in_data_s1.request_function == FC_READ_COILS) ||
		(in_data_s1.request_function == FC_READ_DISCRETE);

	always_comb begin
		result.status         = ST_OK;
		result.frame_length   = 9'(count_n);
		result.exception_code = 8'd0;
		result.raw_value      = 16'd0;
		priority if (count_n < CNT_W'(4)) begin
			result.status = ST_SHORT;
		end else if ({dly1_n, dly0_n} != crc_n) begin
			result.status = ST_CRC_ERR;
		end else if (hdr_n[0][EXC_FLAG_BIT]) begin
			result.status         = ST_EXCEPTION;
			result.exception_code = hdr_n[1];
		end else if (hdr_n[1] == 8'd0) begin
			result.status = ST_NO_DATA;
		end else if (bit_read) begin
			result.raw_value = {15'd0, hdr_n[2][0]};
		end else if ((count_n < CNT_W'(5)) || (hdr_n[1] < 8'd2)) begin
			result.status = ST_NO_DATA;
		end else begin
			result.raw_value = {hdr_n[2], hdr_n[3]};
		end
	end

	// Frame state: advance on each byte, clear after the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			dly0_q  <= 8'd0;
			dly1_q  <= 8'd0;
			count_q <= '0;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= 8'd0;
			end
		end else if (advance) begin
			if (in_data_s1.end_of_frame) begin
				crc_q   <= CRC_INIT;
				dly0_q  <= 8'd0;
				dly1_q  <= 8'd0;
				count_q <= '0;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= 8'd0;
				end
			end else begin
				crc_q   <= crc_n;
				dly0_q  <= dly0_n;
				dly1_q  <= dly1_n;
				count_q <= count_n;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= hdr_n[i];
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && in_data_s1.end_of_frame) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_data_s1.end_of_frame) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== design/mrc_checker.sv =====
// Port-level checker for the Modbus RTU response checker, with its bind.
`default_nettype none

`include "modbus_rtu_response_checker_assert.svh"

module mrc_checker import mrc_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire mrc_out_t out_data
);

	logic stalled;
	logic not_ok;
	logic not_exc;
	logic not_short;

	// Qualify the result status
	assign stalled   = out_valid && out_stall;
	assign not_ok    = out_valid && (out_data.status != ST_OK);
	assign not_exc   = out_valid && (out_data.status != ST_EXCEPTION);
	assign not_short = out_valid && (out_data.status != ST_SHORT);

	// Hold a stalled item
	`MRC_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled result changed")

	// Raw value only on a good frame
	`MRC_ASSERT_NOW(a_raw_zero, not_ok, out_data.raw_value == 16'd0, "raw value on failed frame")

	// Exception code only on an exception
	`MRC_ASSERT_NOW(a_exc_zero, not_exc, out_data.exception_code == 8'd0, "stray exception code")

	// Any status but short needs at least four bytes
	`MRC_ASSERT_NOW(a_len_short, not_short, out_data.frame_length >= 9'd4, "short frame missed")

endmodule

bind modbus_rtu_response_checker mrc_checker u_mrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
